>>> rtl/bba_pkg.sv
package bba_pkg;

  localparam int MapBits  = 4096;
  localparam int MapWords = 64;
  localparam int WordW    = 64;
  localparam int AddrW    = 12;
  localparam int CountW   = 13;
  localparam int WIdxW    = 6;
  localparam int BIdxW    = 6;

  // Input command codes
  localparam logic [2:0] CMD_READ   = 3'd0;
  localparam logic [2:0] CMD_SET    = 3'd1;
  localparam logic [2:0] CMD_CLEAR  = 3'd2;
  localparam logic [2:0] CMD_SETR   = 3'd3;
  localparam logic [2:0] CMD_CLEARR = 3'd4;
  localparam logic [2:0] CMD_ALLOC  = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOB  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_READ,
    OP_WRITE,
    OP_ALLOC
  } bba_op_t;

  // One classified job passed from front to back
  typedef struct packed {
    bba_op_t                  op;
    logic                     set_val;
    logic [AddrW-1:0]         start;
    logic [CountW-1:0]        stop;     // exclusive end, above start for real work
    logic [1:0]               status;
  } bba_job_t;

  // Index of lowest set bit of a word
  function automatic logic [BIdxW-1:0] first_one(input logic [WordW-1:0] w);
    logic [BIdxW-1:0] idx;
    idx = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (w[i]) idx = BIdxW'(i);
    end
    return idx;
  endfunction

endpackage

>>> rtl/bba_front.sv
module bba_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [2:0]              cmd,
  input  logic [11:0]             addr,
  input  logic [12:0]             cnt,
  input  logic [12:0]             map_size,
  output logic                    job_valid,
  output bba_pkg::bba_job_t       job,
  input  logic                    job_pop
);
  import bba_pkg::*;

  bba_job_t    q_r [2];
  logic        wptr_r, rptr_r;
  logic [1:0]  cnt_r;
  logic [12:0] size;
  logic [13:0] sum;
  logic [12:0] cl_end;
  bba_job_t    cls;
  logic        push;

  // Clamp size to the map and classify the command
  always_comb begin
    size   = (map_size > 13'(MapBits)) ? 13'(MapBits) : map_size;
    sum    = {2'b0, addr} + {1'b0, cnt};
    cl_end = (sum > {1'b0, size}) ? size : sum[12:0];
    cls         = '0;
    cls.op      = OP_NONE;
    cls.start   = addr;
    cls.stop    = {1'b0, addr} + 13'd1;
    cls.set_val = (cmd == CMD_SET) || (cmd == CMD_SETR);
    case (cmd)
      CMD_READ, CMD_SET, CMD_CLEAR: begin
        if ({1'b0, addr} >= size) cls.status = ST_OOB;
        else cls.op = (cmd == CMD_READ) ? OP_READ : OP_WRITE;
      end
      CMD_SETR: begin
        if (sum > {1'b0, size}) cls.status = ST_OOB;
        else if (cnt != '0) begin
          cls.op   = OP_WRITE;
          cls.stop = sum[12:0];
        end
      end
      CMD_CLEARR: begin
        if ({1'b0, addr} < cl_end) begin
          cls.op   = OP_WRITE;
          cls.stop = cl_end;
        end
      end
      CMD_ALLOC: begin
        if ({1'b0, addr} >= size) cls.status = ST_FULL;
        else begin
          cls.op   = OP_ALLOC;
          cls.stop = size;
        end
      end
      default: cls.status = ST_OK;
    endcase
  end

  // Two-entry queue toward the back end
  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (job_pop) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(job_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wptr_r] <= cls;
  end

endmodule

>>> rtl/bba_back.sv
module bba_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    job_valid,
  input  bba_pkg::bba_job_t       job,
  output logic                    job_pop,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [15:0]             out_tdata
);
  import bba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_MOD  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  bba_job_t          job_r;
  logic [WIdxW-1:0]  w_r, w_nxt;
  logic [WordW-1:0]  mem [MapWords];
  logic [WordW-1:0]  mem_q;
  logic [MapWords-1:0] valid_r;
  logic              vq_r;
  logic [WordW-1:0]  d, lo_m, hi_m, mask, cand, wdata;
  logic              we, rd_en;
  logic [WIdxW-1:0]  last_w;
  logic [AddrW-1:0]  stop_m1;
  logic              bit_r, bit_nxt;
  logic [AddrW-1:0]  fnd_r, fnd_nxt;
  logic [1:0]        st_r, st_nxt;
  logic              ov_r;
  logic [BIdxW-1:0]  fidx;

  assign stop_m1 = AddrW'(job_r.stop - 13'd1);
  assign last_w  = stop_m1[AddrW-1:BIdxW];
  assign d       = vq_r ? mem_q : '0;

  // Build the mask of bits in range within the current word
  always_comb begin
    lo_m = (w_r == job_r.start[AddrW-1:BIdxW]) ? ({WordW{1'b1}} << job_r.start[BIdxW-1:0])
                                              : {WordW{1'b1}};
    if (w_r == last_w && job_r.stop[BIdxW-1:0] != '0)
      hi_m = ~({WordW{1'b1}} << job_r.stop[BIdxW-1:0]);
    else
      hi_m = {WordW{1'b1}};
    mask = lo_m & hi_m;
    cand = ~d & mask;
    fidx = first_one(cand);
  end

  // Sequence one job word by word
  always_comb begin
    state_nxt = state_r;
    w_nxt     = w_r;
    bit_nxt   = bit_r;
    fnd_nxt   = fnd_r;
    st_nxt    = st_r;
    job_pop   = 1'b0;
    we        = 1'b0;
    rd_en     = 1'b0;
    wdata     = d;
    case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          w_nxt   = job.start[AddrW-1:BIdxW];
          bit_nxt = 1'b0;
          fnd_nxt = '0;
          st_nxt  = job.status;
          state_nxt = (job.op == OP_NONE) ? S_OUT : S_READ;
        end
      end
      S_READ: begin
        rd_en     = 1'b1;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        case (job_r.op)
          OP_READ: begin
            bit_nxt   = d[job_r.start[BIdxW-1:0]];
            state_nxt = S_OUT;
          end
          OP_WRITE: begin
            we    = 1'b1;
            wdata = job_r.set_val ? (d | mask) : (d & ~mask);
            if (w_r == last_w) state_nxt = S_OUT;
            else begin
              w_nxt     = w_r + 1'b1;
              state_nxt = S_READ;
            end
          end
          OP_ALLOC: begin
            if (cand != '0) begin
              we        = 1'b1;
              wdata     = d | (WordW'(1) << fidx);
              fnd_nxt   = {w_r, fidx};
              state_nxt = S_OUT;
            end else if (w_r == last_w) begin
              st_nxt    = ST_FULL;
              state_nxt = S_OUT;
            end else begin
              w_nxt     = w_r + 1'b1;
              state_nxt = S_READ;
            end
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_OUT: begin
        if (!ov_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (we) valid_r[w_r] <= 1'b1;
      if (state_r == S_OUT && (!ov_r || out_tready)) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    w_r   <= w_nxt;
    bit_r <= bit_nxt;
    fnd_r <= fnd_nxt;
    st_r  <= st_nxt;
    if (job_pop) job_r <= job;
    if (rd_en) begin
      mem_q <= mem[w_r];
      vq_r  <= valid_r[w_r];
    end
    if (we) mem[w_r] <= wdata;
    if (state_r == S_OUT && (!ov_r || out_tready)) out_tdata <= {1'b0, st_r, fnd_r, bit_r};
  end

  assign out_tvalid = ov_r;

  a_write_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> state_r == S_MOD) else $error("word write outside modify step");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> state_r == S_IDLE) else $error("job taken while busy");
  a_word_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD && job_r.op != OP_NONE) |-> w_r <= last_w)
    else $error("scan ran past last word");

endmodule

>>> rtl/bitmap_block_allocator.sv
// Bitmap block allocator: one bit per block, 4096 bits in 64 words of 64 bits,
// all free after reset. A command word enters a two-entry queue and is then
// run by a back end against a single-port word memory, one read-modify-write
// of one word at a time, in a read step and then a modify step. Out-of-bounds
// and empty commands skip the memory; a single-bit access touches one word; a
// range or allocate command repeats both steps for each word it touches, up to
// all 64 words for a full scan. cfg_wr_data sets the number of bits in use and
// must only change while the block is idle.
module bitmap_block_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data,   // map_size
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,      // command[2:0], bit_address[14:3], bit_count[27:15]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata      // bit_value[0], found_address[12:1], status[14:13]
);
  import bba_pkg::*;

  logic [12:0] map_size_r;
  logic        job_valid, job_pop;
  bba_job_t    job;

  // Hold the map size register
  always_ff @(posedge clk) begin
    if (!rst_n) map_size_r <= 13'(MapBits);
    else if (cfg_wr_en) map_size_r <= cfg_wr_data;
  end

  bba_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (in_tdata[2:0]),
    .addr      (in_tdata[14:3]),
    .cnt       (in_tdata[27:15]),
    .map_size  (map_size_r),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  bba_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (job_valid),
    .job        (job),
    .job_pop    (job_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
